// File: hw/rtl/bdcl_pkg.sv
// ----------------------------------------------------------------------------
// bdcl_pkg
// Shared types and constants for the button debounce / click / long press
// qualifier.
// ----------------------------------------------------------------------------
package bdcl_pkg;

   localparam int unsigned TIME_W = 32;
   localparam int unsigned CFG_W  = 16;

   // request tdata: raw_down, now_ms, zero fill to 40 bits
   localparam int unsigned REQ_DATA_W = 40;
   // response tdata: down, pressed, released, click, long_press, hold_ms, fill
   localparam int unsigned RSP_DATA_W = 40;

   // register indexes
   localparam logic REG_DEBOUNCE   = 1'b0;
   localparam logic REG_LONG_PRESS = 1'b1;

   // request kinds carried in tuser
   localparam logic ACT_SAMPLE = 1'b0;
   localparam logic ACT_RESYNC = 1'b1;

   localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd50;
   localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd600;

   typedef struct packed {
      logic              action;
      logic              raw_down;
      logic [TIME_W-1:0] now_ms;
   } req_item_type;

   typedef struct packed {
      logic              down;
      logic              pressed;
      logic              released;
      logic              click;
      logic              long_press;
      logic [TIME_W-1:0] hold_ms;
   } rsp_item_type;

   typedef struct packed {
      logic [CFG_W-1:0] debounce_ms;
      logic [CFG_W-1:0] long_press_ms;
   } cfg_type;

endpackage

// File: hw/rtl/bdcl_in_stage.sv
// ----------------------------------------------------------------------------
// bdcl_in_stage
// Input register: captures one request and holds it until the core takes it.
// ----------------------------------------------------------------------------
module bdcl_in_stage
   import bdcl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  req_item_type in_item,
   output logic         out_valid,
   input  logic         out_take,
   output req_item_type out_item
);

   logic         valid_ff, valid_in;
   req_item_type item_ff, item_in;

   // free when empty or when the held request leaves this cycle
   assign in_ready = !valid_ff || out_take;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (in_ready) begin
         valid_in = in_valid;
         if (in_valid) begin
            item_in = in_item;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// File: hw/rtl/bdcl_core.sv
// ----------------------------------------------------------------------------
// bdcl_core
// Debounce and press tracking state, one request per cycle while the
// response slot is free or draining, with the registered response stage.
// ----------------------------------------------------------------------------
module bdcl_core
   import bdcl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         in_valid,
   output logic         in_take,
   input  req_item_type in_item,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item
);

   logic              raw_level_ff, raw_level_in;
   logic [TIME_W-1:0] raw_changed_ff, raw_changed_in;
   logic              stable_ff, stable_in;
   logic [TIME_W-1:0] press_time_ff, press_time_in;
   logic              long_sent_ff, long_sent_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_item_type      rsp_ff, rsp_in;

   logic              changed;
   logic [TIME_W-1:0] elapsed;
   logic              settled;
   logic              edge_hit;
   logic              press_hit;
   logic              long_clr;
   logic [TIME_W-1:0] hold;
   logic              long_hit;

   // take a request when the response slot is free or draining
   assign in_take = in_valid && (!rsp_valid_ff || rsp_ready);

   // sample path
   always_comb begin
      changed   = in_item.raw_down != raw_level_ff;
      elapsed   = changed ? '0 : in_item.now_ms - raw_changed_ff;
      settled   = elapsed >= {{(TIME_W-CFG_W){1'b0}}, cfg.debounce_ms};
      edge_hit  = settled && (stable_ff != in_item.raw_down);
      press_hit = edge_hit && in_item.raw_down;
      long_clr  = press_hit ? 1'b0 : long_sent_ff;
      // on the press itself the hold time is zero
      hold      = press_hit ? '0 : in_item.now_ms - press_time_ff;
      long_hit  = (edge_hit ? in_item.raw_down : stable_ff) && !long_clr &&
                  (hold >= {{(TIME_W-CFG_W){1'b0}}, cfg.long_press_ms});
   end

   // next state and response
   always_comb begin
      raw_level_in   = raw_level_ff;
      raw_changed_in = raw_changed_ff;
      stable_in      = stable_ff;
      press_time_in  = press_time_ff;
      long_sent_in   = long_sent_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      if (in_take) begin
         rsp_valid_in = 1'b1;
         if (in_item.action == ACT_RESYNC) begin
            raw_level_in   = in_item.raw_down;
            stable_in      = in_item.raw_down;
            raw_changed_in = in_item.now_ms;
            press_time_in  = in_item.now_ms;
            long_sent_in   = 1'b0;
            rsp_in         = '0;
            rsp_in.down    = in_item.raw_down;
         end else begin
            raw_level_in = in_item.raw_down;
            if (changed) begin
               raw_changed_in = in_item.now_ms;
            end
            if (edge_hit) begin
               stable_in = in_item.raw_down;
            end
            if (press_hit) begin
               press_time_in = in_item.now_ms;
            end
            long_sent_in       = long_clr || long_hit;
            rsp_in.down        = stable_in;
            rsp_in.pressed     = press_hit;
            rsp_in.released    = edge_hit && !in_item.raw_down;
            rsp_in.click       = edge_hit && !in_item.raw_down && !long_sent_ff;
            rsp_in.long_press  = long_hit;
            rsp_in.hold_ms     = stable_in ? hold : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_level_ff   <= 1'b0;
         raw_changed_ff <= '0;
         stable_ff      <= 1'b0;
         press_time_ff  <= '0;
         long_sent_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         raw_level_ff   <= raw_level_in;
         raw_changed_ff <= raw_changed_in;
         stable_ff      <= stable_in;
         press_time_ff  <= press_time_in;
         long_sent_ff   <= long_sent_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// File: hw/rtl/button_debounce_click_longpress.sv
// ----------------------------------------------------------------------------
// button_debounce_click_longpress
// Push-button qualifier: debounce, press/release edges, click and long press.
// ----------------------------------------------------------------------------
// Each request carries the raw button level and a wrapping millisecond
// timestamp and produces exactly one response. The block takes one request
// per clock while the response side is ready; any response stall holds off
// req_tready in the same cycle once both registers are full. A request passes
// through the input register, then the response register. The rate is set
// by the state update loop, which is combinational: two 32-bit subtractions
// and compares against the thresholds. A resync request (tuser set) loads the
// level and the time directly and reports no edge. Write thresholds through
// csr_* only while no request is in flight.
// ----------------------------------------------------------------------------
module button_debounce_click_longpress
   import bdcl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [0] raw_down, [32:1] now_ms, rest zero
   input  logic                  req_tuser,   // [0] action
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [0] down, [1] pressed, [2] released,
                                              // [3] click, [4] long_press,
                                              // [36:5] hold_ms, rest zero
   // configuration
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CFG_W-1:0]      csr_wdata
);

   cfg_type      cfg_ff, cfg_in;
   req_item_type req_item;
   req_item_type stage_item;
   logic         stage_valid;
   logic         stage_take;
   rsp_item_type rsp_item;

   // threshold registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_DEBOUNCE:   cfg_in.debounce_ms   = csr_wdata;
            REG_LONG_PRESS: cfg_in.long_press_ms = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms   <= DEBOUNCE_RESET;
         cfg_ff.long_press_ms <= LONG_PRESS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // unpack request
   assign req_item.action   = req_tuser;
   assign req_item.raw_down = req_tdata[0];
   assign req_item.now_ms   = req_tdata[TIME_W:1];

   bdcl_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .out_valid (stage_valid),
      .out_take  (stage_take),
      .out_item  (stage_item)
   );

   bdcl_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (stage_valid),
      .in_take   (stage_take),
      .in_item   (stage_item),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_item  (rsp_item)
   );

   // pack response
   assign rsp_tdata = {{(RSP_DATA_W-TIME_W-5){1'b0}}, rsp_item.hold_ms,
                       rsp_item.long_press, rsp_item.click, rsp_item.released,
                       rsp_item.pressed, rsp_item.down};

   // press and release never share a response
   a_edge_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_item.pressed && rsp_item.released))
      else $error("press and release in one response");

   // a click only comes with a release
   a_click_rel: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_item.click) |-> rsp_item.released)
      else $error("click without release");

   // long press and nonzero hold only while down
   a_long_down: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_item.long_press || rsp_item.hold_ms != '0)) |-> rsp_item.down)
      else $error("long press or hold time while up");

   // a press response carries zero hold time
   a_press_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_item.pressed) |-> (rsp_item.hold_ms == '0))
      else $error("hold time nonzero on press");

endmodule
